// ===== hw/rtl/sttd_pkg.sv =====
`default_nettype none

package sttd_pkg;

  // Field widths of the poll item and of the timeout registers.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned MICROS_W = 20;

  // Seconds of a day fit in 17 bits; a day plus a day needs 18.
  localparam int unsigned SECS_W   = 17;
  localparam int unsigned SECS2_W  = SECS_W + 1;
  // Signed width of the elapsed-seconds result (one more bit for the sign).
  localparam int unsigned ELAPSED_W = SECS2_W + 1;
  // Signed width of the microsecond difference.
  localparam int unsigned USDIFF_W  = MICROS_W + 2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [SECS_W-1:0]   DAY_SECS       = SECS_W'(86400);
  localparam logic [SECS_W-1:0]   HOUR_SECS      = SECS_W'(3600);
  localparam logic [SECS_W-1:0]   MINUTE_SECS    = SECS_W'(60);
  localparam logic [MICROS_W:0]   MICROS_PER_SEC = (MICROS_W+1)'(1000000);

  // Register reset values.
  localparam logic [HOUR_W-1:0]   LIMIT_HOURS_RST   = '0;
  localparam logic [MIN_W-1:0]    LIMIT_MINUTES_RST = '0;
  localparam logic [SEC_W-1:0]    LIMIT_SECONDS_RST = SEC_W'(1);
  localparam logic [MICROS_W-1:0] LIMIT_MICROS_RST  = '0;

  // Register index, taken from the word address.
  typedef enum logic [1:0] {
    REG_LIMIT_HOURS   = 2'd0,
    REG_LIMIT_MINUTES = 2'd1,
    REG_LIMIT_SECONDS = 2'd2,
    REG_LIMIT_MICROS  = 2'd3
  } reg_idx_t;

  // Timeout as handed from the register block to the datapath.
  typedef struct packed {
    logic [SECS_W-1:0]   secs;
    logic [MICROS_W-1:0] micros;
  } limit_t;

  // Clock reading to seconds of the day, clamped to one full day.
  function automatic logic [SECS_W-1:0] clock_secs(
    input logic [HOUR_W-1:0] h,
    input logic [MIN_W-1:0]  m,
    input logic [SEC_W-1:0]  s
  );
    logic [SECS_W-1:0] t;
    t = SECS_W'(h) * HOUR_SECS + SECS_W'(m) * MINUTE_SECS + SECS_W'(s);
    return (t > DAY_SECS) ? DAY_SECS : t;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stall_timeout_detector.sv =====
`default_nettype none

// Activity timeout watchdog. Each poll item carries a watched word and the
// wall-clock time; a changed word disarms the timer, a repeated word arms it
// and later repeats compare the elapsed whole seconds (midnight wrap and
// microsecond borrow included) with the programmed timeout, clamped to one
// day. Every poll gives exactly one result: a one-poll expiry pulse and a
// flip bit that toggles on each expiry. One item is accepted per cycle while
// the result side keeps taking results; an item passes an input register and
// then a result register, where its result waits until it is taken. Timeout
// registers sit at byte offsets 0 (hours), 4 (minutes), 8 (seconds) and 12
// (microseconds); the timeout is folded to seconds in the cycle after a write,
// so write it while no polls run.
module stall_timeout_detector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sttd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [sttd_pkg::DATA_W-1:0]      pwdata,
  output logic      [sttd_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sttd_pkg::WORD_W-1:0]      in_watched_value,
  input  wire logic [sttd_pkg::HOUR_W-1:0]      in_now_hour,
  input  wire logic [sttd_pkg::MIN_W-1:0]       in_now_minute,
  input  wire logic [sttd_pkg::SEC_W-1:0]       in_now_second,
  input  wire logic [sttd_pkg::MICROS_W-1:0]    in_now_micros,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_timeout_pulse,
  output logic                                  out_toggle_out
);

  sttd_pkg::limit_t limit;

  // Timeout registers.
  sttd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  // Poll datapath.
  sttd_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .limit             (limit),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_watched_value  (in_watched_value),
    .in_now_hour       (in_now_hour),
    .in_now_minute     (in_now_minute),
    .in_now_second     (in_now_second),
    .in_now_micros     (in_now_micros),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_timeout_pulse (out_timeout_pulse),
    .out_toggle_out    (out_toggle_out)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sttd_regs.sv =====
`default_nettype none

module sttd_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sttd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [sttd_pkg::DATA_W-1:0]      pwdata,
  output logic      [sttd_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready,
  output sttd_pkg::limit_t                      limit
);

  logic [sttd_pkg::HOUR_W-1:0]   hours_r;
  logic [sttd_pkg::MIN_W-1:0]    minutes_r;
  logic [sttd_pkg::SEC_W-1:0]    seconds_r;
  logic [sttd_pkg::MICROS_W-1:0] micros_r;
  logic [sttd_pkg::SECS_W-1:0]   lim_secs_r;
  logic [sttd_pkg::SECS_W-1:0]   lim_secs_nxt;
  sttd_pkg::reg_idx_t            idx;
  logic                          wr_en;

  assign pready = 1'b1;
  assign idx    = sttd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r   <= sttd_pkg::LIMIT_HOURS_RST;
      minutes_r <= sttd_pkg::LIMIT_MINUTES_RST;
      seconds_r <= sttd_pkg::LIMIT_SECONDS_RST;
      micros_r  <= sttd_pkg::LIMIT_MICROS_RST;
    end else if (wr_en) begin
      unique case (idx)
        sttd_pkg::REG_LIMIT_HOURS:   hours_r   <= pwdata[sttd_pkg::HOUR_W-1:0];
        sttd_pkg::REG_LIMIT_MINUTES: minutes_r <= pwdata[sttd_pkg::MIN_W-1:0];
        sttd_pkg::REG_LIMIT_SECONDS: seconds_r <= pwdata[sttd_pkg::SEC_W-1:0];
        sttd_pkg::REG_LIMIT_MICROS:  micros_r  <= pwdata[sttd_pkg::MICROS_W-1:0];
        default: ;
      endcase
    end
  end

  // The timeout total is kept in seconds so the datapath only compares.
  assign lim_secs_nxt = sttd_pkg::clock_secs(hours_r, minutes_r, seconds_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_secs_r <= sttd_pkg::clock_secs(sttd_pkg::LIMIT_HOURS_RST,
                                         sttd_pkg::LIMIT_MINUTES_RST,
                                         sttd_pkg::LIMIT_SECONDS_RST);
    end else begin
      lim_secs_r <= lim_secs_nxt;
    end
  end

  assign limit.secs   = lim_secs_r;
  assign limit.micros = micros_r;

  // Read back.
  always_comb begin
    prdata = '0;
    unique case (idx)
      sttd_pkg::REG_LIMIT_HOURS:   prdata = sttd_pkg::DATA_W'(hours_r);
      sttd_pkg::REG_LIMIT_MINUTES: prdata = sttd_pkg::DATA_W'(minutes_r);
      sttd_pkg::REG_LIMIT_SECONDS: prdata = sttd_pkg::DATA_W'(seconds_r);
      sttd_pkg::REG_LIMIT_MICROS:  prdata = sttd_pkg::DATA_W'(micros_r);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sttd_core.sv =====
`default_nettype none

module sttd_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sttd_pkg::limit_t                 limit,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sttd_pkg::WORD_W-1:0]      in_watched_value,
  input  wire logic [sttd_pkg::HOUR_W-1:0]      in_now_hour,
  input  wire logic [sttd_pkg::MIN_W-1:0]       in_now_minute,
  input  wire logic [sttd_pkg::SEC_W-1:0]       in_now_second,
  input  wire logic [sttd_pkg::MICROS_W-1:0]    in_now_micros,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_timeout_pulse,
  output logic                                  out_toggle_out
);

  localparam int unsigned SW  = sttd_pkg::SECS_W;
  localparam int unsigned S2W = sttd_pkg::SECS2_W;
  localparam int unsigned EW  = sttd_pkg::ELAPSED_W;
  localparam int unsigned UW  = sttd_pkg::USDIFF_W;
  localparam int unsigned MW  = sttd_pkg::MICROS_W;

  // Input stage: the clock reading is folded to seconds on capture.
  logic                         s1_valid_r;
  logic [sttd_pkg::WORD_W-1:0]  s1_word_r;
  logic [SW-1:0]                s1_secs_r;
  logic [MW-1:0]                s1_micros_r;

  // Watchdog state.
  logic [sttd_pkg::WORD_W-1:0]  last_value_r;
  logic                         armed_r;
  logic [SW-1:0]                start_secs_r;
  logic [MW-1:0]                start_micros_r;
  logic                         toggle_r;

  // Result register.
  logic                         out_valid_r;
  logic                         pulse_r;
  logic                         out_toggle_r;

  logic                         s1_go;
  logic                         accept;
  logic                         changed;
  logic                         wrap;
  logic                         borrow;
  logic                         short_us;
  logic                         expire;
  logic [S2W-1:0]               now_ext;
  logic signed [UW-1:0]         us_diff;
  logic signed [EW-1:0]         elapsed;
  logic                         pulse_nxt;
  logic                         toggle_nxt;

  // Handshake: the input stage moves on whenever the result register is free.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r   <= in_watched_value;
      s1_secs_r   <= sttd_pkg::clock_secs(in_now_hour, in_now_minute, in_now_second);
      s1_micros_r <= in_now_micros;
    end
  end

  // Elapsed time since arming, with midnight wrap and microsecond borrow.
  always_comb begin
    changed  = (s1_word_r != last_value_r);
    wrap     = (start_secs_r > s1_secs_r);
    now_ext  = wrap ? (S2W'(s1_secs_r) + S2W'(sttd_pkg::DAY_SECS)) : S2W'(s1_secs_r);
    borrow   = (s1_micros_r < start_micros_r);
    if (borrow) begin
      us_diff = $signed(UW'(sttd_pkg::MICROS_PER_SEC)) - $signed(UW'(start_micros_r))
              + $signed(UW'(s1_micros_r));
    end else begin
      us_diff = $signed(UW'(s1_micros_r)) - $signed(UW'(start_micros_r));
    end
    short_us = (us_diff < $signed(UW'(limit.micros)));
    elapsed  = $signed(EW'(now_ext)) - $signed(EW'(start_secs_r))
             - $signed(EW'(borrow)) - $signed(EW'(short_us));
    expire   = (elapsed >= $signed(EW'(limit.secs)));
    pulse_nxt  = !changed && armed_r && expire;
    toggle_nxt = toggle_r ^ pulse_nxt;
  end

  // State update, once per item leaving the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_value_r   <= '0;
      armed_r        <= 1'b0;
      start_secs_r   <= '0;
      start_micros_r <= '0;
      toggle_r       <= 1'b0;
    end else if (s1_go) begin
      toggle_r <= toggle_nxt;
      if (changed) begin
        last_value_r <= s1_word_r;
        armed_r      <= 1'b0;
      end else if (!armed_r) begin
        armed_r        <= 1'b1;
        start_secs_r   <= s1_secs_r;
        start_micros_r <= s1_micros_r;
      end else if (expire) begin
        armed_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pulse_r      <= pulse_nxt;
      out_toggle_r <= toggle_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_timeout_pulse = pulse_r;
  assign out_toggle_out    = out_toggle_r;

endmodule

`default_nettype wire
